FILE: rtl/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types and alphabet functions for the base64 codec.
// Holds the transaction payload structs and the character <-> sextet maps.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  // Direction register codes.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Character codes of the alphabet boundaries and the pad.
  localparam logic [7:0] ChPad    = 8'h3D;  // '='
  localparam logic [7:0] ChUpperA = 8'h41;  // 'A'
  localparam logic [7:0] ChUpperZ = 8'h5A;  // 'Z'
  localparam logic [7:0] ChLowerA = 8'h61;  // 'a'
  localparam logic [7:0] ChLowerZ = 8'h7A;  // 'z'
  localparam logic [7:0] ChDigit0 = 8'h30;  // '0'
  localparam logic [7:0] ChDigit9 = 8'h39;  // '9'
  localparam logic [7:0] ChPlus   = 8'h2B;  // '+'
  localparam logic [7:0] ChSlash  = 8'h2F;  // '/'

  // Largest number of results one input transaction can cause.
  localparam int unsigned MaxResults = 4;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // A finished group handed from the assembler to the emitter.
  typedef struct packed {
    logic [2:0]                     count;
    out_item_t [MaxResults-1:0]     items;
  } group_t;

  // Decoded sextet with a flag that the character is in the alphabet.
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Map a sextet to its alphabet character.
  function automatic logic [7:0] b64_char(logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < 6'd26)      return ChUpperA + s8;
    else if (s < 6'd52) return ChLowerA + s8 - 8'd26;
    else if (s < 6'd62) return ChDigit0 + s8 - 8'd52;
    else if (s == 6'd62) return ChPlus;
    else                return ChSlash;
  endfunction

  // Map a character to its sextet; ok is low outside the alphabet.
  function automatic sextet_t b64_sextet(logic [7:0] c);
    sextet_t r;
    r = '0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r.ok  = 1'b1;
      r.val = 6'(c - ChUpperA);
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      r.ok  = 1'b1;
      r.val = 6'(c - ChLowerA + 8'd26);
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      r.ok  = 1'b1;
      r.val = 6'(c - ChDigit0 + 8'd52);
    end else if (c == ChPlus) begin
      r.ok  = 1'b1;
      r.val = 6'd62;
    end else if (c == ChSlash) begin
      r.ok  = 1'b1;
      r.val = 6'd63;
    end
    return r;
  endfunction

endpackage

FILE: rtl/b64sc_group.sv
// ----------------------------------------------------------------------------
// b64sc_group: group assembler.
// Holds the direction register and the partial group, and forms the finished
// group of results when an input transaction completes one.
// ----------------------------------------------------------------------------
module b64sc_group (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_write_i,
  input  logic                cfg_data_i,
  input  logic                accept_i,
  input  b64sc_pkg::in_item_t item_i,
  output b64sc_pkg::group_t   group_o
);
  import b64sc_pkg::*;

  logic        dir_q;
  logic [23:0] buf_q, buf_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  pad_q, pad_d;
  logic        bad_q, bad_d;

  logic [23:0] enc_buf, dec_buf;
  logic [2:0]  enc_n, pads, keep;
  logic        is_pad;
  sextet_t     sx;
  logic [5:0]  sval;
  group_t      grp;

  // Result of the group, given the current partial group and the incoming item.
  always_comb begin
    grp    = '0;
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    pad_d  = pad_q;
    bad_d  = bad_q;
    enc_buf = buf_q;
    dec_buf = buf_q;
    enc_n  = {1'b0, cnt_q} + 3'd1;
    pads   = 3'd0;
    keep   = 3'd3;
    is_pad = (item_i.in_byte == ChPad);
    sx     = b64_sextet(item_i.in_byte);
    sval   = (is_pad || !sx.ok) ? 6'd0 : sx.val;

    if (dir_q == DirEncode) begin
      // Place the byte at its final position in the 24-bit group.
      case (cnt_q)
        2'd0:    enc_buf = buf_q | {item_i.in_byte, 16'h0000};
        2'd1:    enc_buf = buf_q | {8'h00, item_i.in_byte, 8'h00};
        default: enc_buf = buf_q | {16'h0000, item_i.in_byte};
      endcase
      case (enc_n)
        3'd1:    pads = 3'd2;
        3'd2:    pads = 3'd1;
        default: pads = 3'd0;
      endcase
      buf_d = enc_buf;
      cnt_d = enc_n[1:0];
      if (enc_n == 3'd3 || item_i.in_last) begin
        grp.count = 3'd4;
        for (int i = 0; i < 4; i++) begin
          grp.items[i].out_byte  = (3'(i) >= 3'd4 - pads) ? ChPad
                                   : b64_char(enc_buf[18-6*i +: 6]);
          grp.items[i].out_last  = item_i.in_last && (i == 3);
          grp.items[i].out_error = 1'b0;
        end
      end
    end else begin
      // Place the sextet and note pads and bad characters.
      case (cnt_q)
        2'd0:    dec_buf = buf_q | {sval, 18'h0};
        2'd1:    dec_buf = buf_q | {6'h0, sval, 12'h0};
        2'd2:    dec_buf = buf_q | {12'h0, sval, 6'h0};
        default: dec_buf = buf_q | {18'h0, sval};
      endcase
      pad_d = pad_q | {is_pad && (cnt_q == 2'd2), is_pad && (cnt_q == 2'd3)};
      bad_d = bad_q | (!is_pad && !sx.ok);
      buf_d = dec_buf;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q != 2'd3) begin
        // A message end inside a group is a length error.
        if (item_i.in_last) begin
          grp.count              = 3'd1;
          grp.items[0].out_byte  = 8'h00;
          grp.items[0].out_last  = 1'b1;
          grp.items[0].out_error = 1'b1;
        end
      end else begin
        if (item_i.in_last) begin
          keep = 3'd3 - {2'b00, pad_d[0]} - {2'b00, pad_d[1]};
        end
        grp.count = keep;
        for (int i = 0; i < 3; i++) begin
          grp.items[i].out_byte  = dec_buf[16-8*i +: 8];
          grp.items[i].out_last  = item_i.in_last && (3'(i) == keep - 3'd1);
          grp.items[i].out_error = bad_d;
        end
      end
    end
  end

  assign group_o = grp;

  // Direction and partial group state; a direction write clears the group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirEncode;
      buf_q <= '0;
      cnt_q <= '0;
      pad_q <= '0;
      bad_q <= 1'b0;
    end else if (cfg_write_i) begin
      dir_q <= cfg_data_i;
      buf_q <= '0;
      cnt_q <= '0;
      pad_q <= '0;
      bad_q <= 1'b0;
    end else if (accept_i) begin
      if (grp.count != 3'd0) begin
        buf_q <= '0;
        cnt_q <= '0;
        pad_q <= '0;
        bad_q <= 1'b0;
      end else begin
        buf_q <= buf_d;
        cnt_q <= cnt_d;
        pad_q <= pad_d;
        bad_q <= bad_d;
      end
    end
  end

endmodule

FILE: rtl/b64sc_emit.sv
// ----------------------------------------------------------------------------
// b64sc_emit: result emitter.
// Holds one finished group in a short shift register and hands its results
// out one transaction per cycle from the head slot while out_stall_i is low.
// ----------------------------------------------------------------------------
module b64sc_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  b64sc_pkg::group_t    group_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64sc_pkg::out_item_t out_o
);
  import b64sc_pkg::*;

  out_item_t [MaxResults-1:0] slot_q;
  logic [2:0]                 cnt_q;
  logic                       take;

  assign take        = (cnt_q != 3'd0) && !out_stall_i;
  // Room for a new group once the last held result leaves.
  assign free_o      = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_o       = slot_q[0];

  // Result slots: no reset needed on the payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= group_i.items;
    end else if (take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  // Count of results still held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= group_i.count;
    end else if (take) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // A group is only loaded when the slots are free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_i |-> free_o)
    else $error("group loaded while results are pending");

  // A loaded group carries between one and four results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   load_i |-> (group_i.count != 3'd0 && group_i.count <= 3'd4))
    else $error("bad group size");

  // The held count never exceeds the slot depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result count overflow");

  // Taking the last held result with nothing loaded empties the emitter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 3'd1 && take && !load_i) |=> !out_valid_o)
    else $error("emitter did not drain");

endmodule

FILE: rtl/base64_stream_codec_core.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_core: streaming base64 encoder and decoder.
// Standard alphabet with '=' padding; the direction register picks the mode.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o  | in_i  (in_byte, in_last)
//   out     | out_valid_o / out_stall_i| out_o (out_byte, out_last, out_error)
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_data_i (direction)
//
// An input transaction that completes a group loads its results into the
// emitter on the same edge; results leave one per cycle from a register
// while the output does not stall. Encoding gives four characters per three
// bytes; decoding takes one character per cycle while the output flows.
// The input stalls only while a completing item finds the emitter busy.
// Reset clears the direction to encode and the partial group; cfg is always
// ready and a write also clears the partial group.
// ----------------------------------------------------------------------------
module base64_stream_codec_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b64sc_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64sc_pkg::out_item_t out_o
);
  import b64sc_pkg::*;

  group_t grp;
  logic   free;
  logic   accept;
  logic   cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Hold off an item only when it would produce results with no room.
  assign in_stall_o = (grp.count != 3'd0) && !free;
  assign accept     = in_valid_i && !in_stall_o;

  b64sc_group u_group (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_write),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_i),
    .group_o     (grp)
  );

  b64sc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (grp.count != 3'd0)),
    .group_i     (grp),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for base64_stream_codec_core.
// A directed table covers the padding, pad-position and bad-input cases in
// both directions. Random messages follow, mostly well-formed with some
// noise, under random idling on both sides. Every result transaction is
// checked against an in-bench model of the codec.
// ----------------------------------------------------------------------------
module tb_top;
  import b64sc_pkg::*;

  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 35;
  localparam int unsigned PhaseCount   = 4;

  // One row of the directed table; first is the first result the row causes.
  typedef struct packed {
    logic       dir;
    logic [7:0] data;
    logic       last;
    logic       typed;
    out_item_t  first;
  } stim_row_t;

  localparam out_item_t Unchecked = '0;

  localparam stim_row_t DirectedRows [0:22] = '{
    // Encode all-zero and all-ones groups.
    '{DirEncode, 8'h00, 1'b0, 1'b0, Unchecked},
    '{DirEncode, 8'h00, 1'b0, 1'b0, Unchecked},
    '{DirEncode, 8'h00, 1'b1, 1'b1, '{8'h41, 1'b0, 1'b0}},
    '{DirEncode, 8'hFF, 1'b0, 1'b0, Unchecked},
    '{DirEncode, 8'hFF, 1'b0, 1'b0, Unchecked},
    '{DirEncode, 8'hFF, 1'b1, 1'b1, '{8'h2F, 1'b0, 1'b0}},
    // One-byte and two-byte final groups.
    '{DirEncode, 8'h4D, 1'b1, 1'b1, '{8'h54, 1'b0, 1'b0}},
    '{DirEncode, 8'h4D, 1'b0, 1'b0, Unchecked},
    '{DirEncode, 8'h61, 1'b1, 1'b0, Unchecked},
    // Partial group left behind; the direction write drops it.
    '{DirEncode, 8'hAB, 1'b0, 1'b0, Unchecked},
    // Decode "TWFu".
    '{DirDecode, 8'h54, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h57, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h46, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h75, 1'b1, 1'b1, '{8'h4D, 1'b0, 1'b0}},
    // Decode "//==": two pads keep a single byte.
    '{DirDecode, 8'h2F, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h2F, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h3D, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h3D, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    // Message end after one character is a bad length.
    '{DirDecode, 8'h51, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
    // Pad in the first position, then two characters outside the alphabet.
    '{DirDecode, 8'h3D, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'hFF, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h00, 1'b0, 1'b0, Unchecked},
    '{DirDecode, 8'h39, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}}
  };

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Stimulus and response signals.
  logic      clk       = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_ready_o;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_o;

  // Model state of the codec.
  logic        codec_dir = DirEncode;
  logic [23:0] grp_buf   = '0;
  int          grp_cnt   = 0;
  logic [1:0]  pad_bits  = '0;
  logic        bad_seen  = 1'b0;

  // Bench bookkeeping.
  out_item_t   awaited_out [$];
  out_item_t   typed_first [int];
  int          sent_count   = 0;
  int          taken_count  = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;
  logic        calm         = 1'b0;
  logic        drv_dir      = DirEncode;

  base64_stream_codec_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_i        (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_o       (out_o)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int sextet_of_char(logic [7:0] c);
    for (int k = 0; k < 64; k++) begin
      if (alphabet[k] == c) return k;
    end
    return 64;
  endfunction

  function automatic void clear_group();
    grp_buf  = '0;
    grp_cnt  = 0;
    pad_bits = '0;
    bad_seen = 1'b0;
  endfunction

  // Works out the result transactions that one input transaction causes.
  function automatic void b64_translate(in_item_t it);
    out_item_t r;
    int        pads;
    int        code;
    int        keep;
    if (codec_dir == DirEncode) begin
      grp_buf = grp_buf | ({16'h0000, it.in_byte} << (16 - 8 * grp_cnt));
      grp_cnt++;
      if (grp_cnt < 3 && !it.in_last) return;
      pads = (grp_cnt == 1) ? 2 : (grp_cnt == 2) ? 1 : 0;
      for (int i = 0; i < 4; i++) begin
        if (i >= 4 - pads) r.out_byte = ChPad;
        else r.out_byte = alphabet[int'((grp_buf >> (18 - 6 * i)) & 24'h3F)];
        r.out_last  = it.in_last && (i == 3);
        r.out_error = 1'b0;
        awaited_out.push_back(r);
      end
      clear_group();
    end else begin
      // A pad counts as zero; in the third or fourth slot it is remembered.
      if (it.in_byte == ChPad) begin
        code = 0;
        if (grp_cnt == 2) pad_bits[1] = 1'b1;
        if (grp_cnt == 3) pad_bits[0] = 1'b1;
      end else begin
        code = sextet_of_char(it.in_byte);
        if (code > 63) begin
          bad_seen = 1'b1;
          code     = 0;
        end
      end
      grp_buf = grp_buf | (24'(code) << (18 - 6 * grp_cnt));
      grp_cnt++;
      if (grp_cnt < 4) begin
        if (it.in_last) begin
          r = '{8'h00, 1'b1, 1'b1};
          awaited_out.push_back(r);
          clear_group();
        end
        return;
      end
      keep = 3;
      if (it.in_last) keep = keep - int'(pad_bits[0]) - int'(pad_bits[1]);
      for (int i = 0; i < keep; i++) begin
        r.out_byte  = 8'(grp_buf >> (16 - 8 * i));
        r.out_last  = it.in_last && (i == keep - 1);
        r.out_error = bad_seen;
        awaited_out.push_back(r);
      end
      clear_group();
    end
  endfunction

  function automatic void match_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (awaited_out.size() == 0) begin
      $error("unexpected result: out_byte %0h out_last %0b out_error %0b",
             got.out_byte, got.out_last, got.out_error);
      mismatches++;
      return;
    end
    want = awaited_out.pop_front();
    match_field("out_byte", want.out_byte, got.out_byte);
    match_field("out_last", 8'(want.out_last), 8'(got.out_last));
    match_field("out_error", 8'(want.out_error), 8'(got.out_error));
  endfunction

  // Watches every transaction, keeps the model in step and checks results.
  always @(posedge clk) begin : monitor
    int base;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) check_result(out_o);
      if (cfg_valid && cfg_ready_o) begin
        codec_dir = cfg_data;
        clear_group();
      end
      if (in_valid && !in_stall_o) begin
        base = awaited_out.size();
        b64_translate(in_item);
        // Table rows with a known first result also cross-check the model.
        if (typed_first.exists(taken_count)) begin
          if (awaited_out.size() == base) begin
            $error("table row %0d: expected a result, model gave none", taken_count);
            mismatches++;
          end else begin
            match_field("table out_byte", typed_first[taken_count].out_byte,
                        awaited_out[base].out_byte);
            match_field("table out_last", 8'(typed_first[taken_count].out_last),
                        8'(awaited_out[base].out_last));
            match_field("table out_error", 8'(typed_first[taken_count].out_error),
                        8'(awaited_out[base].out_error));
          end
        end
        taken_count++;
      end
    end
    // Watchdog on cycles without any transaction.
    if ((out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o) ||
        (in_valid && !in_stall_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Offers one input transaction, with an occasional gap ahead of it.
  task automatic feed_symbol(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_byte: b, in_last: last};
    sent_count++;
    do @(posedge clk); while (in_stall_o);
  endtask

  // Holds the input off until every expected result has left the block.
  task automatic settle_block();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_out.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_direction(logic d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte_message();
    int len;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) feed_symbol(8'($urandom_range(0, 255)), k == len - 1);
  endtask

  // Mostly well-formed text with random padding; the rest is noise.
  task automatic send_text_message();
    int         groups;
    int         pads;
    int         len;
    int         pick;
    logic [7:0] ch;
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 9);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) ch = 8'($urandom_range(0, 255));
        else if (pick == 1) ch = ChPad;
        else ch = alphabet[$urandom_range(0, 63)];
        feed_symbol(ch, k == len - 1);
      end
    end else begin
      groups = $urandom_range(1, 3);
      pads   = $urandom_range(0, 2);
      for (int g = 0; g < groups; g++) begin
        for (int p = 0; p < 4; p++) begin
          if (g == groups - 1 && p >= 4 - pads) ch = ChPad;
          else ch = alphabet[$urandom_range(0, 63)];
          feed_symbol(ch, (g == groups - 1) && (p == 3));
        end
      end
    end
  endtask

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int quota;
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[r]) begin
      if (DirectedRows[r].dir != drv_dir) begin
        settle_block();
        drv_dir = DirectedRows[r].dir;
        write_direction(drv_dir);
      end
      if (DirectedRows[r].typed) typed_first[sent_count] = DirectedRows[r].first;
      feed_symbol(DirectedRows[r].data, DirectedRows[r].last);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle_block();
      if (ph == 0) drv_dir = DirEncode;
      else if (ph == 1) drv_dir = DirDecode;
      else drv_dir = $urandom_range(0, 1) ? DirDecode : DirEncode;
      calm = (ph == PhaseCount - 1);
      write_direction(drv_dir);
      quota = sent_count + PhaseItems;
      while (sent_count < quota) begin
        if (drv_dir == DirEncode) send_byte_message();
        else send_text_message();
        if (!calm && $urandom_range(0, 9) == 0) settle_block();
      end
      // Sometimes leave a partial group for the next direction write to drop.
      if (!calm && $urandom_range(0, 1) == 1) feed_symbol(8'($urandom_range(0, 255)), 1'b0);
    end

    settle_block();
    if (mismatches == 0 && awaited_out.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
